// File: rtl/core/arlp_pkg.sv
// arlp_pkg: shared constants and types for the auto-ranging level percent block
// used by arlp_div and auto_ranging_level_percent_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arlp_pkg;

    localparam int SAMPLE_BITS_DEF     = 12;
    localparam int DEGENERATE_SPAN_DEF = 50;

    localparam int TIME_BITS   = 32;
    localparam int WINDOW_BITS = 24;
    localparam int LVL_BITS    = 7;
    localparam int CFG_BITS    = 1;

    localparam logic [LVL_BITS-1:0]    LVL_MAX        = 7'd100;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RST     = 24'd10000;
    localparam logic [TIME_BITS-1:0]   BOOT_RST       = 32'd0;

    // configuration register indexes
    localparam logic [CFG_BITS-1:0] CFG_BOOT_TIME = 1'b0;
    localparam logic [CFG_BITS-1:0] CFG_WINDOW    = 1'b1;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/arlp_div.sv
// arlp_div: restoring serial divider, one quotient bit per cycle
// quotient is known to fit arlp_pkg::LVL_BITS; depends on arlp_pkg
`timescale 1ns / 1ps
`default_nettype none

module arlp_div #(
    parameter int DEN_BITS = arlp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire arlp_pkg::div_ctrl_t                         ctrl,
    input  wire logic [DEN_BITS+arlp_pkg::LVL_BITS-1:0]      numer,
    input  wire logic [DEN_BITS-1:0]                         denom,
    output logic      [arlp_pkg::LVL_BITS-1:0]               quot,
    output arlp_pkg::div_stat_t                              stat
);

    localparam int QB       = arlp_pkg::LVL_BITS;
    localparam int CNT_BITS = $clog2(QB + 1);

    logic [DEN_BITS-1:0] rem_reg;
    logic [QB-1:0]       num_reg;
    logic [QB-1:0]       quot_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   trial;

    assign shifted = {rem_reg, num_reg[QB-1]};
    assign trial   = shifted - {1'b0, denom};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            quot_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                // top bits are already below the divisor since quotient < 2^QB
                rem_reg  <= numer[DEN_BITS+QB-1:QB];
                num_reg  <= numer[QB-1:0];
                quot_reg <= '0;
                cnt_reg  <= CNT_BITS'(QB);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (!trial[DEN_BITS])
                begin
                    rem_reg <= trial[DEN_BITS-1:0];
                end
                else
                begin
                    rem_reg <= shifted[DEN_BITS-1:0];
                end
                quot_reg <= {quot_reg[QB-2:0], ~trial[DEN_BITS]};
                num_reg  <= {num_reg[QB-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a running division");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider counter ran out while busy");

endmodule

`default_nettype wire

// File: rtl/core/auto_ranging_level_percent_unit.sv
// auto_ranging_level_percent_unit: calibrating min/max tracker and 0..100 level map
// top level; depends on arlp_pkg and arlp_div
//
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_stall    | sample_raw, now_ms
//  out     | output    | out_valid / out_stall  | level_percent, in_calibration,
//          |           |                        | range_low, range_high
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one word passes these steps from acceptance to a loaded result: range update, clamp,
// scale by 100 with divider start, the serial divider steps (one quotient bit each),
// a done step and the load step; the serial divide is the longest part of that.
// in_stall is low only while the sequencer is idle, so a new word is taken only after
// the last one is loaded; a result waiting on out_stall holds the sequencer in its load step.
// cfg_ready is always high; rst_n clears the sequencer, the range (min 4095, max 0).
`timescale 1ns / 1ps
`default_nettype none

module auto_ranging_level_percent_unit #(
    parameter int SAMPLE_BITS     = arlp_pkg::SAMPLE_BITS_DEF,
    parameter int DEGENERATE_SPAN = arlp_pkg::DEGENERATE_SPAN_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [SAMPLE_BITS-1:0]             sample_raw,
    input  wire logic [arlp_pkg::TIME_BITS-1:0]     now_ms,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [arlp_pkg::LVL_BITS-1:0]      level_percent,
    output logic                                    in_calibration,
    output logic      [SAMPLE_BITS-1:0]             range_low,
    output logic      [SAMPLE_BITS-1:0]             range_high,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [arlp_pkg::CFG_BITS-1:0]      cfg_index,
    input  wire logic [arlp_pkg::TIME_BITS-1:0]     cfg_data
);

    localparam int SB        = SAMPLE_BITS;
    localparam int QB        = arlp_pkg::LVL_BITS;
    localparam int NUM_BITS  = SB + QB;
    localparam int SPAN_BITS = $clog2(DEGENERATE_SPAN + 1);
    localparam int WIDE_BITS = ((SPAN_BITS > SB) ? SPAN_BITS : SB) + 1;
    localparam logic [WIDE_BITS-1:0] SPAN_W  = WIDE_BITS'(DEGENERATE_SPAN);
    localparam logic [WIDE_BITS-1:0] SMAX_W  = WIDE_BITS'((1 << SB) - 1);
    localparam logic [SB-1:0]        SMAX    = SB'((1 << SB) - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t                          state_reg;
    logic [arlp_pkg::TIME_BITS-1:0]  boot_reg;
    logic [arlp_pkg::WINDOW_BITS-1:0] window_reg;
    logic [SB-1:0]                   min_reg;
    logic [SB-1:0]                   max_reg;
    logic [SB-1:0]                   sample_reg;
    logic                            cal_reg;
    logic [SB-1:0]                   d_reg;
    logic [SB-1:0]                   span_reg;
    logic                            out_valid_reg;
    logic [QB-1:0]                   level_reg;
    logic                            cal_out_reg;
    logic [SB-1:0]                   low_out_reg;
    logic [SB-1:0]                   high_out_reg;

    logic [arlp_pkg::TIME_BITS-1:0]  elapsed;
    logic                            cal_next;
    logic [SB-1:0]                   min_widen;
    logic [SB-1:0]                   max_widen;
    logic [WIDE_BITS-1:0]            s_wide;
    logic [WIDE_BITS-1:0]            s_up;
    logic [SB-1:0]                   min_next;
    logic [SB-1:0]                   max_next;
    logic                            rev;
    logic [SB-1:0]                   s_clamp;
    logic [SB-1:0]                   d_next;
    logic [SB-1:0]                   span_next;
    logic [NUM_BITS-1:0]             numer;
    logic [QB-1:0]                   quot;
    arlp_pkg::div_ctrl_t             div_ctrl;
    arlp_pkg::div_stat_t             div_stat;
    logic                            out_free;

    // calibration window test, modulo 2^32 elapsed time
    assign elapsed  = now_ms - boot_reg;
    assign cal_next = elapsed < {{(arlp_pkg::TIME_BITS - arlp_pkg::WINDOW_BITS){1'b0}},
                                 window_reg};

    // range widening and degenerate-range repair
    always_comb
    begin
        min_widen = min_reg;
        max_widen = max_reg;
        if (cal_reg)
        begin
            if (sample_reg < min_reg)
            begin
                min_widen = sample_reg;
            end
            if (sample_reg > max_reg)
            begin
                max_widen = sample_reg;
            end
        end
        s_wide   = WIDE_BITS'(sample_reg);
        s_up     = s_wide + SPAN_W;
        min_next = min_widen;
        max_next = max_widen;
        if (min_widen == max_widen)
        begin
            min_next = (s_wide >= SPAN_W) ? SB'(s_wide - SPAN_W) : '0;
            max_next = (s_up > SMAX_W) ? SMAX : SB'(s_up);
        end
    end

    // clamp to the stored range, either orientation
    always_comb
    begin
        rev = min_reg > max_reg;
        if (!rev)
        begin
            s_clamp = (sample_reg < min_reg) ? min_reg :
                      ((sample_reg > max_reg) ? max_reg : sample_reg);
            d_next    = s_clamp - min_reg;
            span_next = max_reg - min_reg;
        end
        else
        begin
            s_clamp = (sample_reg < max_reg) ? max_reg :
                      ((sample_reg > min_reg) ? min_reg : sample_reg);
            d_next    = min_reg - s_clamp;
            span_next = min_reg - max_reg;
        end
    end

    // scaled distance is loaded by the divider in the same step it is formed
    assign numer          = NUM_BITS'(d_reg) * NUM_BITS'(arlp_pkg::LVL_MAX);
    assign div_ctrl.start = (state_reg == ST_MUL);
    assign out_free       = !out_valid_reg || !out_stall;

    arlp_div #(
        .DEN_BITS (SB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .numer (numer),
        .denom (span_reg),
        .quot  (quot),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            boot_reg      <= arlp_pkg::BOOT_RST;
            window_reg    <= arlp_pkg::WINDOW_RST;
            min_reg       <= SMAX;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
            cal_reg       <= 1'b0;
            d_reg         <= '0;
            span_reg      <= '0;
            level_reg     <= '0;
            cal_out_reg   <= 1'b0;
            low_out_reg   <= '0;
            high_out_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    arlp_pkg::CFG_BOOT_TIME: boot_reg   <= cfg_data;
                    arlp_pkg::CFG_WINDOW:    window_reg <= cfg_data[arlp_pkg::WINDOW_BITS-1:0];
                    default:                 boot_reg   <= boot_reg;
                endcase
            end

            // the load step sets valid itself when it takes over a leaving word
            if (out_valid_reg && !out_stall && state_reg != ST_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample_raw;
                        cal_reg    <= cal_next;
                        state_reg  <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    min_reg   <= min_next;
                    max_reg   <= max_next;
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    d_reg     <= d_next;
                    span_reg  <= span_next;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        // a zero span maps to level 0
                        level_reg     <= (span_reg == '0) ? '0 : quot;
                        cal_out_reg   <= cal_reg;
                        low_out_reg   <= min_reg;
                        high_out_reg  <= max_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign level_percent  = level_reg;
    assign in_calibration = cal_out_reg;
    assign range_low      = low_out_reg;
    assign range_high     = high_out_reg;

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result word appeared outside the load step");

    a_range_only_in_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_UPD) |=> $stable(min_reg) && $stable(max_reg))
        else $error("stored range changed outside the update step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> level_reg <= arlp_pkg::LVL_MAX)
        else $error("level above full scale");

    a_range_not_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> min_reg != max_reg)
        else $error("equal range reached the mapping step");

endmodule

`default_nettype wire

// File: verif/auto_ranging_level_percent_unit_tb.sv
`timescale 1ns / 1ps
// auto_ranging_level_percent_unit_tb: self-checking bench for the calibrating level block
// directed words first, then randomized register phases; every word checked by a local predictor
// depends on arlp_pkg and auto_ranging_level_percent_unit

module auto_ranging_level_percent_unit_tb;

    localparam int SB        = arlp_pkg::SAMPLE_BITS_DEF;
    localparam int SPAN      = arlp_pkg::DEGENERATE_SPAN_DEF;
    localparam int FULL      = (1 << SB) - 1;
    localparam int LATENCY   = 12;
    localparam int MAX_SHOWN = 10;
    localparam int TB        = arlp_pkg::TIME_BITS;
    localparam int WB        = arlp_pkg::WINDOW_BITS;
    localparam int LB        = arlp_pkg::LVL_BITS;
    localparam int CB        = arlp_pkg::CFG_BITS;

    typedef logic [SB-1:0] sample_t;
    typedef logic [TB-1:0] stamp_t;

    typedef struct packed {
        logic [LB-1:0] level_percent;
        logic          in_calibration;
        sample_t       range_low;
        sample_t       range_high;
    } level_word_t;

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    logic          in_stall;
    sample_t       sample_raw = '0;
    stamp_t        now_ms     = '0;
    logic          out_valid;
    logic          out_stall  = 1'b0;
    logic [LB-1:0] level_percent;
    logic          in_calibration;
    sample_t       range_low;
    sample_t       range_high;
    logic          cfg_valid  = 1'b0;
    logic          cfg_ready;
    logic [CB-1:0] cfg_index  = arlp_pkg::CFG_BOOT_TIME;
    stamp_t        cfg_data   = '0;

    // local copy of the registers and the tracked range
    stamp_t        boot_reg   = arlp_pkg::BOOT_RST;
    logic [WB-1:0] window_reg = arlp_pkg::WINDOW_RST;
    sample_t       track_min  = sample_t'(FULL);
    sample_t       track_max  = '0;

    level_word_t expected_words[$];
    bit          gaps_on   = 1'b1;
    int          n_errors  = 0;
    int          n_samples = 0;
    int          n_words   = 0;
    int          n_cal     = 0;
    int          n_configs = 1;

    auto_ranging_level_percent_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_raw     (sample_raw),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .level_percent  (level_percent),
        .in_calibration (in_calibration),
        .range_low      (range_low),
        .range_high     (range_high),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit in_window(input stamp_t t);
        stamp_t elapsed;
        elapsed = t - boot_reg;
        return elapsed < {{(TB - WB){1'b0}}, window_reg};
    endfunction

    function automatic level_word_t predict_level(input sample_t s, input stamp_t t);
        level_word_t w;
        int          sv;
        int          lo;
        int          hi;
        int          offs;
        int          span_w;
        sv = s;
        w.in_calibration = in_window(t);
        if (w.in_calibration)
        begin
            if (s < track_min) track_min = s;
            if (s > track_max) track_max = s;
        end
        // a collapsed range is reopened around the sample and kept
        if (track_min == track_max)
        begin
            track_min = (sv >= SPAN) ? sample_t'(sv - SPAN) : '0;
            track_max = (sv + SPAN > FULL) ? sample_t'(FULL) : sample_t'(sv + SPAN);
        end
        lo = track_min;
        hi = track_max;
        if (lo <= hi)
        begin
            if (sv < lo) sv = lo;
            if (sv > hi) sv = hi;
            span_w = hi - lo;
            offs   = sv - lo;
        end
        else
        begin
            // reversed range maps inversely
            if (sv < hi) sv = hi;
            if (sv > lo) sv = lo;
            span_w = lo - hi;
            offs   = lo - sv;
        end
        w.level_percent = (span_w == 0) ? '0 :
                          LB'(offs * int'(arlp_pkg::LVL_MAX) / span_w);
        w.range_low     = track_min;
        w.range_high    = track_max;
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic stamp_t pick_stamp();
        int unsigned w;
        w = window_reg;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return boot_reg - $urandom_range(1, 5000);
            3:       return boot_reg + w - 1 + $urandom_range(0, 2);
            default: return boot_reg + $urandom_range(0, 2 * w + 1);
        endcase
    endfunction

    // calibrating samples stay in a band early on so the range widens slowly
    function automatic sample_t pick_sample(input stamp_t t, input int band);
        if (band < FULL / 2 && in_window(t))
            return sample_t'($urandom_range(FULL / 2 - band, FULL / 2 + band));
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? sample_t'(FULL) : '0;
        return sample_t'($urandom());
    endfunction

    task automatic send_sample(input sample_t s, input stamp_t t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        sample_raw <= s;
        now_ms     <= t;
        do @(posedge clk); while (in_stall);
        expected_words.push_back(predict_level(s, t));
        n_samples++;
        if (expected_words[$].in_calibration) n_cal++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
    endtask

    task automatic write_reg(input logic [CB-1:0] idx, input stamp_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == arlp_pkg::CFG_BOOT_TIME)
            boot_reg = data;
        else
            window_reg = data[WB-1:0];
    endtask

    task automatic configure(input stamp_t boot, input stamp_t win_data);
        write_reg(arlp_pkg::CFG_BOOT_TIME, boot);
        write_reg(arlp_pkg::CFG_WINDOW, win_data);
        cfg_valid <= 1'b0;
        n_configs++;
    endtask

    // reset range is reversed until a sample lands in the window
    task automatic test_reversed_range();
        send_sample('0, stamp_t'(arlp_pkg::WINDOW_RST));
        send_sample(sample_t'(FULL), '1);
        send_sample(sample_t'(2048), 32'h8000_0000);
        send_sample(sample_t'(1), 32'd12345);
        send_sample(sample_t'(FULL - 1), 32'h0001_0000);
    endtask

    // first calibrating sample collapses the range; reopened span may clip at either end
    task automatic test_degenerate_range();
        sample_t first;
        case ($urandom_range(0, 2))
            0:       first = sample_t'(20);
            1:       first = sample_t'(FULL - 20);
            default: first = sample_t'(2048);
        endcase
        send_sample(first, stamp_t'(arlp_pkg::WINDOW_RST) - 1);
        send_sample('0, 32'd20000);
        send_sample(sample_t'(FULL), stamp_t'(arlp_pkg::WINDOW_RST));
        send_sample(first, '0);
    endtask

    task automatic test_zero_window();
        drain();
        configure($urandom(), '0);
        send_sample('0, boot_reg);
        send_sample(sample_t'(FULL), boot_reg + 1);
        send_sample(sample_t'(1234), $urandom());
        send_sample(sample_t'(FULL - 1), boot_reg - 1);
    endtask

    // window straddles the 32-bit wrap of the millisecond counter
    task automatic test_wrapping_time();
        drain();
        configure(32'hFFFF_FFF0, 32'd100);
        send_sample(sample_t'(1500), 32'hFFFF_FFF0);
        send_sample(sample_t'(2600), 32'h0000_0053);
        send_sample('0, 32'h0000_0054);
        send_sample(sample_t'(FULL), 32'hFFFF_FFEF);
        send_sample(sample_t'(2000), '0);
    endtask

    // widest window, upper data bits set to check they are dropped
    task automatic test_window_limit();
        drain();
        configure($urandom(), {8'hA5, 24'hFF_FFFF});
        send_sample(sample_t'(1800), boot_reg + 32'h00FF_FFFE);
        send_sample(sample_t'(2300), boot_reg);
        send_sample('0, boot_reg + 32'h00FF_FFFF);
        send_sample(sample_t'(FULL), boot_reg - 1);
    endtask

    task automatic test_random_phases();
        int     phase;
        int     k;
        stamp_t win_data;
        stamp_t t;
        for (phase = 0; phase < 8; phase++)
        begin
            drain();
            case (phase)
                0:       win_data = '0;
                7:       win_data = {8'($urandom_range(0, 255)), 24'hFF_FFFF};
                default: win_data = (phase % 2) ? $urandom_range(1, 20000)
                                                : $urandom_range(1, 24'hFF_FFFF);
            endcase
            configure($urandom(), win_data);
            gaps_on = (phase != 3);
            for (k = 0; k < 50; k++)
            begin
                // sender holds off once until the pipe is empty
                if (phase == 5 && k == 25) drain();
                t = pick_stamp();
                send_sample(pick_sample(t, (phase < 6) ? 150 * (phase + 1) : FULL), t);
            end
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin : result_side
        int hold;
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_word
        level_word_t want;
        level_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.level_percent  = level_percent;
            got.in_calibration = in_calibration;
            got.range_low      = range_low;
            got.range_high     = range_high;
            if (expected_words.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_SHOWN)
                    $display("unexpected word: level %0d cal %0b range %0d..%0d",
                             got.level_percent, got.in_calibration,
                             got.range_low, got.range_high);
            end
            else
            begin
                want = expected_words.pop_front();
                n_words++;
                if (got !== want)
                begin
                    n_errors++;
                    if (n_errors <= MAX_SHOWN)
                        $display("word %0d: expected %0d/%0b/%0d..%0d got %0d/%0b/%0d..%0d",
                                 n_words, want.level_percent, want.in_calibration,
                                 want.range_low, want.range_high,
                                 got.level_percent, got.in_calibration,
                                 got.range_low, got.range_high);
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reversed_range();
        test_degenerate_range();
        test_zero_window();
        test_wrapping_time();
        test_window_limit();
        test_random_phases();
        drain();
        repeat (4 * LATENCY) @(posedge clk);
        $display("sent %0d samples (%0d inside the calibration window) over %0d register settings",
                 n_samples, n_cal, n_configs);
        $display("checked %0d level words, %0d left pending, %0d errors",
                 n_words, expected_words.size(), n_errors);
        if (n_errors == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
